// File: src/nffa_pkg.sv
`default_nettype none

package nffa_pkg;

   localparam int ADDR_W      = 32;
   localparam int FRAME_SHIFT = 22;
   localparam int FRAME_NUM_W = ADDR_W - FRAME_SHIFT;

   localparam logic [FRAME_NUM_W-1:0] BASE_RESET = FRAME_NUM_W'(20);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef struct packed {
      command_type        command;
      logic [ADDR_W-1:0]  release_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  frame_address;
      logic               ok;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/next_fit_frame_allocator_unit.sv
// A request waits in the request register, its result in the response register;
// a stalled rsp side can hold both.
// Throughput: one request per cycle while the rsp side does not stall; the bitmap search
// and update sit between the request register and the response register, so back-to-back
// requests see each other's effect.
// Reset (synchronous): all frames free, search pointer at frame 0, pool base 20.
`default_nettype none

module next_fit_frame_allocator_unit import nffa_pkg::*; #(
   parameter int FRAME_COUNT = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire req_type                req_data,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rsp_type                rsp_data,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [FRAME_NUM_W-1:0] csr_pool_base_frame
);

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   req_type                in_data_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   rsp_type                out_data_ff;
   logic [FRAME_NUM_W-1:0] base_ff;
   logic [FRAME_NUM_W-1:0] base_in;

   logic                   out_free;
   logic                   fire;
   rsp_type                result;

   nffa_pool #(
      .FRAME_COUNT (FRAME_COUNT),
      .IDX_W       (IDX_W)
   ) u_pool (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .req         (in_data_ff),
      .base_frame  (base_ff),
      .result      (result)
   );

   // The request register drains whenever the response register can take a result.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      out_valid_in = fire ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
      base_in      = csr_valid ? csr_pool_base_frame : base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

// File: src/nffa_search.sv
`default_nettype none

module nffa_search import nffa_pkg::*; #(
   parameter int FRAME_COUNT = 12,
   parameter int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
   input  wire logic [FRAME_COUNT-1:0] used_map,
   input  wire logic [IDX_W-1:0]       next_index,
   input  wire logic [FRAME_NUM_W-1:0] base_frame,
   output      logic                   found,
   output      logic [IDX_W-1:0]       found_index
);

   logic [FRAME_COUNT-1:0] avail;
   logic [FRAME_COUNT-1:0] upper;
   logic [FRAME_COUNT-1:0] pick;
   logic [FRAME_COUNT-1:0] first;
   logic [FRAME_NUM_W:0]   frame_sum;

   always_comb begin
      frame_sum = '0;
      // A frame exists only if its base address still fits in 32 bits.
      for (int i = 0; i < FRAME_COUNT; i++) begin
         frame_sum = {1'b0, base_frame} + (FRAME_NUM_W+1)'(i);
         avail[i]  = !used_map[i] && !frame_sum[FRAME_NUM_W];
         upper[i]  = avail[i] && (int'(next_index) <= i);
      end
      // Frames at or after the pointer win; otherwise wrap to the lowest one.
      pick  = (|upper) ? upper : avail;
      first = pick & (~pick + FRAME_COUNT'(1));
      found = |avail;
      found_index = '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         found_index = found_index | (first[i] ? IDX_W'(i) : IDX_W'(0));
      end
   end

endmodule

`default_nettype wire

// File: src/nffa_pool.sv
`default_nettype none

module nffa_pool import nffa_pkg::*; #(
   parameter int FRAME_COUNT = 12,
   parameter int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire req_type                req,
   input  wire logic [FRAME_NUM_W-1:0] base_frame,
   output      rsp_type                result
);

   logic [FRAME_COUNT-1:0] used_ff;
   logic [FRAME_COUNT-1:0] used_in;
   logic [IDX_W-1:0]       next_ff;
   logic [IDX_W-1:0]       next_in;

   logic                   found;
   logic [IDX_W-1:0]       found_index;
   logic [FRAME_NUM_W-1:0] rel_frame;
   logic [FRAME_NUM_W:0]   rel_diff;
   logic                   in_pool;
   logic [FRAME_NUM_W-1:0] alloc_frame;
   logic [IDX_W:0]         next_inc;
   logic [FRAME_COUNT-1:0] set_mask;
   logic [FRAME_COUNT-1:0] clr_mask;

   nffa_search #(
      .FRAME_COUNT (FRAME_COUNT),
      .IDX_W       (IDX_W)
   ) u_search (
      .used_map    (used_ff),
      .next_index  (next_ff),
      .base_frame  (base_frame),
      .found       (found),
      .found_index (found_index)
   );

   always_comb begin
      rel_frame   = req.release_address[ADDR_W-1:FRAME_SHIFT];
      rel_diff    = {1'b0, rel_frame} - {1'b0, base_frame};
      in_pool     = (rel_frame >= base_frame) &&
                    (rel_diff < (FRAME_NUM_W+1)'(FRAME_COUNT));
      alloc_frame = base_frame + FRAME_NUM_W'(found_index);
      next_inc    = (IDX_W+1)'(found_index) + (IDX_W+1)'(1);
      for (int i = 0; i < FRAME_COUNT; i++) begin
         set_mask[i] = found && (found_index == IDX_W'(i));
         clr_mask[i] = in_pool && (rel_diff == (FRAME_NUM_W+1)'(i));
      end

      used_in = used_ff;
      next_in = next_ff;
      result  = '0;
      unique case (req.command)
         CMD_ALLOC: begin
            if (found) begin
               used_in = used_ff | set_mask;
               next_in = (next_inc == (IDX_W+1)'(FRAME_COUNT)) ? IDX_W'(0)
                                                               : next_inc[IDX_W-1:0];
               result.frame_address = {alloc_frame, {FRAME_SHIFT{1'b0}}};
            end
            result.ok = found;
         end
         CMD_FREE: begin
            used_in   = used_ff & ~clr_mask;
            result.ok = in_pool;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         next_ff <= '0;
      end else if (fire) begin
         used_ff <= used_in;
         next_ff <= next_in;
      end
   end

endmodule

`default_nettype wire

// File: dv/tb_next_fit_frame_allocator_unit.sv
`timescale 1ns / 100ps

module tb_next_fit_frame_allocator_unit;
   import nffa_pkg::*;

   localparam int FRAME_COUNT      = 12;
   localparam longint FRAME_BYTES  = 64'h0040_0000;
   localparam int ADDR_FRAMES      = 1024;
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 210;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 6;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      command_type       command;
      logic [ADDR_W-1:0] release_address;
      bit                known;
      logic [ADDR_W-1:0] frame_address;
      logic              ok;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 24;

   // Rows run at the reset pool base (frame 20, address 0x0500_0000).
   // Where known is clear, the expected result comes from the predictor.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_FREE,  32'h0500_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h0500_0000, 1'b1},
      '{CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'h0540_0000, 1'b1},
      '{CMD_ALLOC, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h07C0_0000, 1'b1},
      '{CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FREE,  32'h04FF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FREE,  32'h0800_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FREE,  32'h07FF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
      '{CMD_FREE,  32'h0500_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h0500_0000, 1'b1},
      '{CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h07C0_0000, 1'b1},
      '{CMD_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FREE,  32'h0623_4567, 1'b0, 32'h0000_0000, 1'b0}
   };

   localparam int SENDER_IDLE_PCT [4]   = '{0, 78, 0, 33};
   localparam int RECEIVER_STALL_PCT [4] = '{0, 0, 78, 33};

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [FRAME_NUM_W-1:0] csr_pool_base_frame = BASE_RESET;

   // Shadow copy of the allocator state.
   logic [FRAME_COUNT-1:0] used_frames = '0;
   int                     next_frame = 0;
   logic [FRAME_NUM_W-1:0] pool_base = BASE_RESET;

   rsp_type pending_grants [$];
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      request_count = 0;
   int      grants_made = 0;
   int      pool_full_count = 0;
   int      frees_in_pool = 0;
   int      frees_outside = 0;

   next_fit_frame_allocator_unit #(.FRAME_COUNT(FRAME_COUNT)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_pool_base_frame (csr_pool_base_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_grants.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            note_mismatch($sformatf("unexpected result addr=%h ok=%b",
                                    rsp_data.frame_address, rsp_data.ok));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.frame_address !== want.frame_address)
               note_mismatch($sformatf("frame_address expected %h got %h",
                                       want.frame_address, rsp_data.frame_address));
            if (rsp_data.ok !== want.ok)
               note_mismatch($sformatf("ok expected %b got %b", want.ok, rsp_data.ok));
         end
      end
   end

   // Next-fit search and release against the shadow state.
   function automatic rsp_type serve_request(req_type r);
      rsp_type res;
      int      present;
      int      idx;
      bit      found;
      longint  lo;
      longint  hi;
      longint  addr;
      res = '0;
      found = 1'b0;
      present = ADDR_FRAMES - int'(pool_base);
      if (present > FRAME_COUNT)
         present = FRAME_COUNT;
      if (r.command == CMD_ALLOC) begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            idx = (next_frame + i) % FRAME_COUNT;
            if (!found && idx < present && !used_frames[idx]) begin
               found = 1'b1;
               used_frames[idx] = 1'b1;
               next_frame = (idx + 1) % FRAME_COUNT;
               res.frame_address = ADDR_W'((longint'(pool_base) + idx) << FRAME_SHIFT);
               res.ok = 1'b1;
            end
         end
      end else begin
         lo = longint'(pool_base) << FRAME_SHIFT;
         hi = lo + FRAME_COUNT * FRAME_BYTES;
         addr = longint'({32'h0, r.release_address});
         if (addr >= lo && addr < hi) begin
            idx = int'((addr - lo) >> FRAME_SHIFT);
            used_frames[idx] = 1'b0;
            res.ok = 1'b1;
         end
      end
      return res;
   endfunction

   // Mostly addresses inside the pool, some at its edges, the rest anywhere.
   function automatic logic [ADDR_W-1:0] pick_release_address();
      longint lo;
      longint hi;
      int     sel;
      lo = longint'(pool_base) << FRAME_SHIFT;
      hi = lo + FRAME_COUNT * FRAME_BYTES;
      sel = $urandom_range(0, 9);
      if (sel < 7)
         return ADDR_W'(lo + longint'($urandom_range(0, FRAME_COUNT - 1)) * FRAME_BYTES
                        + longint'($urandom_range(0, int'(FRAME_BYTES) - 1)));
      if (sel == 7) begin
         case ($urandom_range(0, 3))
            0: return ADDR_W'(lo - 1);
            1: return ADDR_W'(lo);
            2: return ADDR_W'(hi - 1);
            default: return ADDR_W'(hi);
         endcase
      end
      return $urandom();
   endfunction

   // Entered and left just after a falling edge.
   task automatic issue_request(input req_type r, input bit known, input rsp_type known_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted = serve_request(r);
      request_count++;
      if (r.command == CMD_ALLOC) begin
         if (predicted.ok) grants_made++;
         else pool_full_count++;
      end else begin
         if (predicted.ok) frees_in_pool++;
         else frees_outside++;
      end
      pending_grants.push_back(known ? known_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic write_pool_base(input logic [FRAME_NUM_W-1:0] value);
      csr_valid           <= 1'b1;
      csr_pool_base_frame <= value;
      do @(posedge clock); while (!csr_ready);
      pool_base = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [FRAME_NUM_W-1:0] phase_base [PHASES];
      req_type                r;
      rsp_type                known_rsp;
      int                     alloc_pct;
      phase_base = '{BASE_RESET, 10'd0, 10'd1023, 10'd1015, 10'd1012, 10'd0, BASE_RESET, 10'd0};
      phase_base[5] = FRAME_NUM_W'($urandom_range(21, 1011));
      phase_base[7] = FRAME_NUM_W'($urandom_range(1013, 1022));
      alloc_pct = 50;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle_pct    = SENDER_IDLE_PCT[phase % 4];
         receiver_stall_pct = RECEIVER_STALL_PCT[phase % 4];
         if (phase == 0) begin
            foreach (directed_rows[i]) begin
               r.command               = directed_rows[i].command;
               r.release_address       = directed_rows[i].release_address;
               known_rsp.frame_address = directed_rows[i].frame_address;
               known_rsp.ok            = directed_rows[i].ok;
               issue_request(r, directed_rows[i].known, known_rsp);
            end
         end else begin
            write_pool_base(phase_base[phase]);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Swing between filling and draining so the pool hits full and empty.
            if (n % 30 == 0)
               case ($urandom_range(0, 2))
                  0: alloc_pct = 20;
                  1: alloc_pct = 50;
                  default: alloc_pct = 80;
               endcase
            r.command = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
            r.release_address = (r.command == CMD_FREE) ? pick_release_address() : $urandom();
            issue_request(r, 1'b0, '0);
         end
         req_valid <= 1'b0;
         while (pending_grants.size() != 0) @(negedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests over %0d pool bases (reset value, 0, mid-range, 1012-1023).",
               request_count, PHASES);
      $display("Grants %0d, full-pool misses %0d, frees in pool %0d, outside %0d.",
               grants_made, pool_full_count, frees_in_pool, frees_outside);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
